>>> src/rrt_pkg.sv
// Shared types, codes and default sizes for the routing rule table.
package rrt_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int NODE_BITS_DEF = 8;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FIND  = 2'd2;

    localparam logic [STATUS_BITS-1:0] STS_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STS_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] STS_MISS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } rrt_state_t;

endpackage

>>> src/rrt_cmd_if.sv
// Command channel: valid/ready handshake carrying one table command.
interface rrt_cmd_if
    import rrt_pkg::*;
#(
    parameter int NODE_BITS = NODE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [CMD_BITS-1:0]  command;
    logic [NODE_BITS-1:0] src_node;
    logic [NODE_BITS-1:0] dst_node;
    logic [NODE_BITS-1:0] hop_node;

    modport source (output valid, output command, output src_node, output dst_node,
                    output hop_node, input ready);
    modport sink (input valid, input command, input src_node, input dst_node,
                  input hop_node, output ready);
endinterface

>>> src/rrt_res_if.sv
// Result channel: valid/ready handshake carrying one command result.
interface rrt_res_if
    import rrt_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int IDX_BITS = $clog2(DEPTH),
    parameter int CNT_BITS = $clog2(DEPTH + 1)
);
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [IDX_BITS-1:0]    match_index;
    logic [CNT_BITS-1:0]    entry_count;

    modport source (output valid, output status, output match_index, output entry_count,
                    input ready);
    modport sink (input valid, input status, input match_index, input entry_count,
                  output ready);
endinterface

>>> src/rrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rrt_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> src/rrt_ctrl.sv
// Command sequencer: fill count, append writes, linear find scan and result register.
module rrt_ctrl
    import rrt_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int NODE_BITS = NODE_BITS_DEF,
    parameter int IDX_BITS  = $clog2(DEPTH),
    parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    rrt_cmd_if.sink                cmd,
    rrt_res_if.source              res,
    output logic                   ram_we,
    output logic [IDX_BITS-1:0]    ram_waddr,
    output logic [3*NODE_BITS-1:0] ram_wdata,
    output logic                   ram_re,
    output logic [IDX_BITS-1:0]    ram_raddr,
    input  logic [3*NODE_BITS-1:0] ram_rdata
);
    rrt_state_t             state_reg, state_next;
    logic [CNT_BITS-1:0]    fill_reg, fill_next;
    logic [IDX_BITS-1:0]    chk_reg, chk_next;
    logic [NODE_BITS-1:0]   key_src_reg, key_src_next;
    logic [NODE_BITS-1:0]   key_dst_reg, key_dst_next;
    logic [STATUS_BITS-1:0] fstat_reg, fstat_next;
    logic [IDX_BITS-1:0]    fidx_reg, fidx_next;
    logic                   rvalid_reg, rvalid_next;
    logic [STATUS_BITS-1:0] rstat_reg, rstat_next;
    logic [IDX_BITS-1:0]    ridx_reg, ridx_next;
    logic [CNT_BITS-1:0]    rcnt_reg, rcnt_next;
    logic                   out_free;
    logic                   accept;
    logic                   full;
    logic                   hit;
    logic                   last;

    assign out_free = !rvalid_reg || res.ready;
    assign full     = (fill_reg == CNT_BITS'(DEPTH));
    assign hit      = (ram_rdata[2*NODE_BITS-1:NODE_BITS] == key_src_reg)
                      && (ram_rdata[NODE_BITS-1:0] == key_dst_reg);
    assign last     = ((CNT_BITS'(chk_reg) + CNT_BITS'(1)) == fill_reg);

    assign cmd.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    assign ram_we    = accept && (cmd.command == CMD_ADD) && !full;
    assign ram_waddr = fill_reg[IDX_BITS-1:0];
    assign ram_wdata = {cmd.hop_node, cmd.src_node, cmd.dst_node};
    assign ram_re    = (accept && (cmd.command == CMD_FIND) && (fill_reg != '0))
                       || ((state_reg == ST_SCAN) && !hit && !last);
    assign ram_raddr = accept ? '0 : IDX_BITS'(chk_reg + IDX_BITS'(1));

    assign res.valid       = rvalid_reg;
    assign res.status      = rstat_reg;
    assign res.match_index = ridx_reg;
    assign res.entry_count = rcnt_reg;

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        chk_next     = chk_reg;
        key_src_next = key_src_reg;
        key_dst_next = key_dst_reg;
        fstat_next   = fstat_reg;
        fidx_next    = fidx_reg;
        rvalid_next  = rvalid_reg && !res.ready;
        rstat_next   = rstat_reg;
        ridx_next    = ridx_reg;
        rcnt_next    = rcnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rvalid_next = 1'b1;
                    rstat_next  = STS_OK;
                    ridx_next   = '0;
                    rcnt_next   = fill_reg;
                    case (cmd.command)
                        CMD_CLEAR:
                        begin
                            fill_next = '0;
                            rcnt_next = '0;
                        end
                        CMD_ADD:
                        begin
                            if (full)
                            begin
                                rstat_next = STS_FULL;
                            end
                            else
                            begin
                                fill_next = fill_reg + CNT_BITS'(1);
                                rcnt_next = fill_reg + CNT_BITS'(1);
                            end
                        end
                        CMD_FIND:
                        begin
                            if (fill_reg == '0)
                            begin
                                rstat_next = STS_MISS;
                            end
                            else
                            begin
                                rvalid_next  = 1'b0;
                                state_next   = ST_SCAN;
                                chk_next     = '0;
                                key_src_next = cmd.src_node;
                                key_dst_next = cmd.dst_node;
                            end
                        end
                        default:
                        begin
                            rstat_next = STS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    fstat_next = STS_OK;
                    fidx_next  = chk_reg;
                    state_next = ST_DONE;
                end
                else if (last)
                begin
                    fstat_next = STS_MISS;
                    fidx_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    chk_next = IDX_BITS'(chk_reg + IDX_BITS'(1));
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rvalid_next = 1'b1;
                    rstat_next  = fstat_reg;
                    ridx_next   = fidx_reg;
                    rcnt_next   = fill_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg     <= chk_next;
        key_src_reg <= key_src_next;
        key_dst_reg <= key_dst_next;
        fstat_reg   <= fstat_next;
        fidx_reg    <= fidx_next;
        rstat_reg   <= rstat_next;
        ridx_reg    <= ridx_next;
        rcnt_reg    <= rcnt_next;
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_BITS'(DEPTH))
        else $error("fill count exceeds table depth");

    a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && (rstat_reg == STS_FULL)) |-> (rcnt_reg == CNT_BITS'(DEPTH)))
        else $error("full status reported below table depth");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (fill_reg == $past(fill_reg) + CNT_BITS'(1)))
        else $error("append did not advance the fill count");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !ram_we)
        else $error("table written during a find scan");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && (ridx_reg != '0)) |-> (CNT_BITS'(ridx_reg) < rcnt_reg))
        else $error("match index outside the held rules");
`endif
endmodule

>>> src/route_rule_table.sv
// Top level of the routing rule table: command sequencer and rule memory.
//
// The block holds up to DEPTH routing rules (source, destination, next hop) in
// one synchronous RAM, appended in order. Clear and add complete in the cycle
// the command transaction is accepted, and their result transaction is
// presented on the following cycle. Find reads the stored rules one per cycle
// from index zero through the single RAM read port, and a find on an empty
// table completes at once. A new command is accepted whenever no find is in
// progress and the result register is empty or being emptied in the same
// cycle. No initialisation pass is needed after reset.
module route_rule_table
    import rrt_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int NODE_BITS = NODE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rrt_cmd_if.sink   cmd,
    rrt_res_if.source res
);
    localparam int IDX_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic                   ram_we;
    logic [IDX_BITS-1:0]    ram_waddr;
    logic [3*NODE_BITS-1:0] ram_wdata;
    logic                   ram_re;
    logic [IDX_BITS-1:0]    ram_raddr;
    logic [3*NODE_BITS-1:0] ram_rdata;

    rrt_ctrl #(
        .DEPTH     (DEPTH),
        .NODE_BITS (NODE_BITS),
        .IDX_BITS  (IDX_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    rrt_ram #(
        .WIDTH     (3 * NODE_BITS),
        .DEPTH     (DEPTH),
        .ADDR_BITS (IDX_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule
